// ----- hdl/score_based_way_replacement_defines.svh -----
// assertion macros for the score-based way replacement block
// expects signals named clk and rst in the including module

`ifndef SCORE_BASED_WAY_REPLACEMENT_DEFINES_SVH
`define SCORE_BASED_WAY_REPLACEMENT_DEFINES_SVH

// property checked at every edge outside reset
`define SBWR_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SBWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/sbwr_pkg.sv -----
// shared types, constants and helpers of the score-based way replacement block
// no dependencies
`timescale 1ns / 1ps

package sbwr_pkg;

  localparam int NUM_SETS_DEFAULT   = 256;
  localparam int NUM_WAYS_DEFAULT   = 8;
  localparam int SCORE_BITS_DEFAULT = 6;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SCORE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_INCREMENT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VICTIM_THRESHOLD = 2'd3;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] INITIAL_SCORE_RESET    = 6'd32;
  localparam logic [CFG_W-1:0] HIT_INCREMENT_RESET    = 6'd40;
  localparam logic [CFG_W-1:0] DECAY_STEP_RESET       = 6'd1;
  localparam logic [CFG_W-1:0] VICTIM_THRESHOLD_RESET = 6'd24;

  // outcome codes
  localparam logic [1:0] OUT_HIT     = 2'd0;
  localparam logic [1:0] OUT_FILL    = 2'd1;
  localparam logic [1:0] OUT_REPLACE = 2'd2;

  typedef struct packed {
    logic [7:0] set_index;
    logic [7:0] hit_mask;
    logic [7:0] valid_mask;
  } item_t;

  typedef struct packed {
    logic [2:0]  chosen_way;
    logic [10:0] line_number;
    logic [1:0]  outcome;
  } result_t;

  // remainder of an 8-bit set index by the set count, restoring subtraction
  function automatic logic [7:0] set_reduce(input logic [7:0] v, input int unsigned n);
    logic [31:0] rem;
    logic [31:0] d;
    rem = {24'd0, v};
    for (int k = 7; k >= 0; k--) begin
      d = 32'(n) << k;
      if (rem >= d) begin
        rem = rem - d;
      end
    end
    return rem[7:0];
  endfunction

endpackage

// ----- hdl/score_based_way_replacement.sv -----
// top level of the score-based way replacement block
// depends on sbwr_pkg, sbwr_ram and score_based_way_replacement_defines.svh
`timescale 1ns / 1ps
// usage
//   input channel: a word (set_index, hit_mask, valid_mask) is taken at a rising
//   edge with start high and busy low
//   output channel: done is high for exactly one cycle with the result word
//   (chosen_way, line_number, outcome); the receiver cannot hold it off
//   configuration: cfg_write with cfg_index and cfg_data writes one register at
//   once; write only while no word is in flight
// timing
//   a taken word gives its result once the set's score row has been read,
//   evaluated and written back, and busy falls in the cycle that done is high, so
//   a new word is taken only once the last one's result is out; the row lives in
//   the score memory (one row per set, registered read)
// reset
//   rst (synchronous) restores the register defaults and sets the random counter
//   to one, then a clearing pass writes zero to every row with busy high;
//   configuration writes are taken during the pass
// random pick
//   residues of the random counter modulo every candidate count are kept
//   alongside it, so the pick needs no divider

`include "score_based_way_replacement_defines.svh"

module score_based_way_replacement #(
  parameter int NUM_SETS   = sbwr_pkg::NUM_SETS_DEFAULT,
  parameter int NUM_WAYS   = sbwr_pkg::NUM_WAYS_DEFAULT,
  parameter int SCORE_BITS = sbwr_pkg::SCORE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  sbwr_pkg::item_t                    item,
  output logic                               done,
  output sbwr_pkg::result_t                  result,
  input  logic                               cfg_write,
  input  logic [sbwr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbwr_pkg::CFG_W-1:0]         cfg_data
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int CNT_W = $clog2(NUM_WAYS + 1);
  localparam int ROW_W = NUM_WAYS * SCORE_BITS;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_WRITE
  } state_t;

  state_t state;

  // configuration registers
  logic [sbwr_pkg::CFG_W-1:0] initial_score;
  logic [sbwr_pkg::CFG_W-1:0] hit_increment;
  logic [sbwr_pkg::CFG_W-1:0] decay_step;
  logic [sbwr_pkg::CFG_W-1:0] victim_threshold;

  // random counter and its residues, res[i] is the counter modulo i+1
  logic [31:0]      counter;
  logic [WAY_W-1:0] res      [NUM_WAYS];
  logic [WAY_W-1:0] res_next [NUM_WAYS];

  // clearing pass address
  logic [SET_W-1:0] clr_addr;

  // word held while in flight
  logic [SET_W-1:0]    set_q;
  logic [NUM_WAYS-1:0] hit_q;
  logic [NUM_WAYS-1:0] valid_q;
  logic [ROW_W-1:0]    row_q;
  logic [WAY_W-1:0]    way_q;
  logic [1:0]          outcome_q;

  // memory ports
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [SET_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;

  // evaluation signals
  logic [SCORE_BITS-1:0] score [NUM_WAYS];
  logic                  hit_found;
  logic [WAY_W-1:0]      hit_way;
  logic                  free_found;
  logic [WAY_W-1:0]      free_way;
  logic [NUM_WAYS-1:0]   cand;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_m1;
  logic [WAY_W-1:0]      min_way;
  logic [WAY_W-1:0]      pick;
  logic [CNT_W-1:0]      run;
  logic                  rnd_found;
  logic [WAY_W-1:0]      rnd_way;
  logic [WAY_W-1:0]      eval_way;
  logic [1:0]            eval_outcome;
  logic                  bump;

  // write-back signals
  logic [ROW_W-1:0]  new_row;
  logic [31:0]       line_full;

  assign busy = (state != S_IDLE);

  // set reduction happens on the way into the read address
  assign ram_raddr = SET_W'(sbwr_pkg::set_reduce(item.set_index, NUM_SETS));

  assign ram_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : set_q;
  assign ram_wdata = (state == S_CLEAR) ? '0 : new_row;

  sbwr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_scores (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // residues after one more increment; a wrap to zero clears them all
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      if ((counter == '1) || (res[i] == WAY_W'(i))) begin
        res_next[i] = '0;
      end else begin
        res_next[i] = res[i] + 1'b1;
      end
    end
  end

  // evaluate the row read from memory
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      score[w] = ram_rdata[w*SCORE_BITS +: SCORE_BITS];
    end

    // lowest hit way
    hit_found = 1'b0;
    hit_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (hit_q[w] && !hit_found) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
    end

    // lowest invalid way
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!valid_q[w] && !free_found) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end

    // random candidates and their count
    cnt = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      cand[w] = (score[w] <= SCORE_BITS'(victim_threshold));
      cnt     = cnt + CNT_W'(cand[w]);
    end
    cnt_m1 = cnt - 1'b1;

    // first way with the minimum score
    min_way = '0;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (score[w] < score[min_way]) begin
        min_way = WAY_W'(w);
      end
    end

    // pick-th candidate counting from way 0
    pick      = res_next[cnt_m1[WAY_W-1:0]];
    run       = '0;
    rnd_found = 1'b0;
    rnd_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (cand[w]) begin
        if (!rnd_found && (run == CNT_W'(pick))) begin
          rnd_found = 1'b1;
          rnd_way   = WAY_W'(w);
        end
        run = run + 1'b1;
      end
    end

    bump = 1'b0;
    if (hit_found) begin
      eval_way     = hit_way;
      eval_outcome = sbwr_pkg::OUT_HIT;
    end else if (free_found) begin
      eval_way     = free_way;
      eval_outcome = sbwr_pkg::OUT_FILL;
    end else if (cnt == '0) begin
      eval_way     = min_way;
      eval_outcome = sbwr_pkg::OUT_REPLACE;
    end else begin
      eval_way     = rnd_way;
      eval_outcome = sbwr_pkg::OUT_REPLACE;
      bump         = 1'b1;
    end
  end

  // updated row: chosen way boosted or reloaded, the rest decay towards zero
  always_comb begin
    logic [SCORE_BITS-1:0] s;
    logic [SCORE_BITS:0]   sum;
    for (int w = 0; w < NUM_WAYS; w++) begin
      s   = row_q[w*SCORE_BITS +: SCORE_BITS];
      sum = {1'b0, s} + (SCORE_BITS+1)'(hit_increment);
      if (WAY_W'(w) == way_q) begin
        if (outcome_q == sbwr_pkg::OUT_HIT) begin
          new_row[w*SCORE_BITS +: SCORE_BITS] = sum[SCORE_BITS] ? SCORE_MAX
                                                                : sum[SCORE_BITS-1:0];
        end else begin
          new_row[w*SCORE_BITS +: SCORE_BITS] = SCORE_BITS'(initial_score);
        end
      end else if (s >= SCORE_BITS'(decay_step)) begin
        new_row[w*SCORE_BITS +: SCORE_BITS] = s - SCORE_BITS'(decay_step);
      end else begin
        new_row[w*SCORE_BITS +: SCORE_BITS] = '0;
      end
    end
  end

  // line number, upper bits dropped
  assign line_full = 32'(set_q) + 32'(way_q) * 32'(NUM_SETS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      done             <= 1'b0;
      counter          <= 32'd1;
      for (int i = 0; i < NUM_WAYS; i++) begin
        res[i] <= (i == 0) ? '0 : WAY_W'(1);
      end
      initial_score    <= sbwr_pkg::INITIAL_SCORE_RESET;
      hit_increment    <= sbwr_pkg::HIT_INCREMENT_RESET;
      decay_step       <= sbwr_pkg::DECAY_STEP_RESET;
      victim_threshold <= sbwr_pkg::VICTIM_THRESHOLD_RESET;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          sbwr_pkg::REG_INITIAL_SCORE:    initial_score    <= cfg_data;
          sbwr_pkg::REG_HIT_INCREMENT:    hit_increment    <= cfg_data;
          sbwr_pkg::REG_DECAY_STEP:       decay_step       <= cfg_data;
          sbwr_pkg::REG_VICTIM_THRESHOLD: victim_threshold <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_CLEAR: begin
          if (clr_addr == SET_W'(NUM_SETS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            set_q   <= ram_raddr;
            hit_q   <= item.hit_mask[NUM_WAYS-1:0];
            valid_q <= item.valid_mask[NUM_WAYS-1:0];
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          row_q     <= ram_rdata;
          way_q     <= eval_way;
          outcome_q <= eval_outcome;
          if (bump) begin
            counter <= counter + 32'd1;
            res     <= res_next;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          done               <= 1'b1;
          result.chosen_way  <= 3'(way_q);
          result.line_number <= line_full[10:0];
          result.outcome     <= outcome_q;
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a taken word gives its result after the read, evaluate and write-back steps
  `SBWR_ASSERT_PROP(a_result_latency, (start && !busy) |-> ##3 done, "result word missing")
  // results are spaced by the read-evaluate-write sequence
  `SBWR_ASSERT_NEXT(a_done_single, done, !done, "result strobe held twice")
  // the chosen way is always a present way
  `SBWR_ASSERT_PROP(a_way_range, done |-> (result.chosen_way <= 3'(NUM_WAYS - 1)),
                    "chosen way out of range")

endmodule

// ----- hdl/sbwr_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module sbwr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- test/tb_score_based_way_replacement.sv -----
// testbench for the score-based way replacement block: directed corner words, then
// mostly well-formed cache traffic checked against an in-bench score table predictor
// depends on sbwr_pkg and score_based_way_replacement
`timescale 1ns / 1ps

module tb_score_based_way_replacement;
  import sbwr_pkg::*;

  localparam int SETS  = NUM_SETS_DEFAULT;
  localparam int WAYS  = NUM_WAYS_DEFAULT;
  localparam int SCORE_TOP = (1 << SCORE_BITS_DEFAULT) - 1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  item_t                item = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state: one score per way per set, plus the victim pick counter
  logic [SCORE_BITS_DEFAULT-1:0] way_score_table [SETS][WAYS];
  logic [31:0]                   pick_counter;
  logic [CFG_W-1:0]              fill_score;
  logic [CFG_W-1:0]              hit_bonus;
  logic [CFG_W-1:0]              decay_amount;
  logic [CFG_W-1:0]              victim_limit;

  // results owed by the block, oldest first
  result_t expected_choices [$];
  int      fail_count = 0;

  // stimulus-side view of which ways each set holds, for well-formed traffic
  logic [7:0] valid_shadow [SETS];
  bit         burst_mode = 1'b0;
  logic [7:0] hot_sets [8] = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd200, 8'd254, 8'd255};

  score_based_way_replacement u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    // keep the log short if the block is badly broken
    if (fail_count <= 100) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  // scores cleared, registers at their defaults, counter at one
  task automatic clear_predictor();
    for (int s = 0; s < SETS; s++) begin
      valid_shadow[s] = 8'h00;
      for (int k = 0; k < WAYS; k++) begin
        way_score_table[s][k] = '0;
      end
    end
    pick_counter = 32'd1;
    fill_score   = INITIAL_SCORE_RESET;
    hit_bonus    = HIT_INCREMENT_RESET;
    decay_amount = DECAY_STEP_RESET;
    victim_limit = VICTIM_THRESHOLD_RESET;
  endtask

  // works out the chosen way and outcome of one access and updates the scores
  function automatic result_t predict_access(input item_t w);
    logic [7:0]  s;
    int unsigned way;
    logic [1:0]  kind;
    bit          found;
    bit          picked;
    int unsigned cand;
    int unsigned min_way;
    int unsigned pick;
    logic [6:0]  sum;
    result_t     r;
    s     = w.set_index;
    way   = 0;
    kind  = OUT_REPLACE;
    found = 1'b0;
    // a hit wins even on a way marked invalid
    for (int k = 0; k < WAYS; k++) begin
      if (!found && w.hit_mask[k]) begin
        way   = k;
        kind  = OUT_HIT;
        found = 1'b1;
      end
    end
    for (int k = 0; k < WAYS; k++) begin
      if (!found && !w.valid_mask[k]) begin
        way   = k;
        kind  = OUT_FILL;
        found = 1'b1;
      end
    end
    if (!found) begin
      cand    = 0;
      min_way = 0;
      for (int k = 0; k < WAYS; k++) begin
        if (way_score_table[s][k] <= victim_limit) cand++;
        if (way_score_table[s][k] < way_score_table[s][min_way]) min_way = k;
      end
      if (cand == 0) begin
        way = min_way;
      end else begin
        // counter steps only when there is a candidate to pick from
        pick_counter = pick_counter + 32'd1;
        pick   = pick_counter % cand;
        picked = 1'b0;
        for (int k = 0; k < WAYS; k++) begin
          if (!picked && way_score_table[s][k] <= victim_limit) begin
            if (pick == 0) begin
              way    = k;
              picked = 1'b1;
            end else begin
              pick--;
            end
          end
        end
      end
    end
    for (int k = 0; k < WAYS; k++) begin
      if (k != way) begin
        way_score_table[s][k] = (way_score_table[s][k] >= decay_amount) ?
                                way_score_table[s][k] - decay_amount : '0;
      end
    end
    if (kind == OUT_HIT) begin
      sum = {1'b0, way_score_table[s][way]} + {1'b0, hit_bonus};
      way_score_table[s][way] = (sum > SCORE_TOP) ? SCORE_TOP[5:0] : sum[5:0];
    end else begin
      way_score_table[s][way] = fill_score;
    end
    r.chosen_way  = 3'(way);
    r.line_number = 11'(s) + 11'(way * SETS);
    r.outcome     = kind;
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 15);
  endfunction

  // start is left high after a word is taken, so back-to-back words never
  // drop and raise it in the same step
  task automatic send_word(input item_t w, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    expected_choices.push_back(predict_access(w));
  endtask

  // hold off until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (expected_choices.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_INITIAL_SCORE:    fill_score   = val;
      REG_HIT_INCREMENT:    hit_bonus    = val;
      REG_DECAY_STEP:       decay_amount = val;
      REG_VICTIM_THRESHOLD: victim_limit = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_W-1:0] init_v, input logic [CFG_W-1:0] inc_v,
                            input logic [CFG_W-1:0] dec_v, input logic [CFG_W-1:0] thr_v);
    write_reg(REG_INITIAL_SCORE, init_v);
    write_reg(REG_HIT_INCREMENT, inc_v);
    write_reg(REG_DECAY_STEP, dec_v);
    write_reg(REG_VICTIM_THRESHOLD, thr_v);
    cfg_write <= 1'b0;
  endtask

  // mostly coherent traffic on a few hot sets, the rest raw noise
  function automatic item_t make_access();
    item_t       w;
    logic [7:0]  s;
    logic [7:0]  v;
    int unsigned k;
    if ($urandom_range(0, 9) < 3) begin
      w = item_t'(24'($urandom));
      return w;
    end
    s = ($urandom_range(0, 7) == 0) ? 8'($urandom) : hot_sets[$urandom_range(0, 7)];
    if ($urandom_range(0, 19) == 0) begin
      // line invalidated behind the block's back
      valid_shadow[s][$urandom_range(0, 7)] = 1'b0;
    end
    v = valid_shadow[s];
    w.set_index  = s;
    w.valid_mask = v;
    w.hit_mask   = 8'h00;
    if (v != 8'h00 && $urandom_range(0, 1) == 1) begin
      do k = $urandom_range(0, 7); while (!v[k]);
      w.hit_mask[k] = 1'b1;
    end else if (v != 8'hFF) begin
      // a miss fills the lowest free way
      k = 0;
      while (v[k]) k++;
      valid_shadow[s][k] = 1'b1;
    end
    return w;
  endfunction

  task automatic run_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) drain_results();
      send_word(make_access(), draw_gap());
    end
  endtask

  // reset defaults, field extremes, hit on an invalid way, fill, random and
  // minimum-score replacement, hit saturation
  task automatic test_directed_corners();
    send_word('{8'd0,   8'h00, 8'h00}, draw_gap());
    send_word('{8'd255, 8'h80, 8'hFF}, draw_gap());
    send_word('{8'd255, 8'hFF, 8'hFF}, draw_gap());
    send_word('{8'd1,   8'h04, 8'h00}, draw_gap());
    send_word('{8'd2,   8'h00, 8'hFF}, draw_gap());
    send_word('{8'd2,   8'h00, 8'h7F}, draw_gap());
    send_word('{8'd4,   8'h20, 8'h20}, draw_gap());
    send_word('{8'd4,   8'h20, 8'h20}, draw_gap());
    // fill set 3 way by way so every score ends above the threshold
    for (int k = 0; k < WAYS; k++) begin
      send_word('{8'd3, 8'h00, 8'((1 << k) - 1)}, draw_gap());
    end
    send_word('{8'd3,   8'h00, 8'hFF}, draw_gap());
    send_word('{8'd3,   8'h00, 8'hFF}, draw_gap());
    send_word('{8'd128, 8'hAA, 8'h55}, draw_gap());
    send_word('{8'd127, 8'h00, 8'h55}, draw_gap());
  endtask

  // registers at all-zero, all-ones and mixed extremes
  task automatic test_config_corners();
    drain_results();
    set_config(6'd0, 6'd0, 6'd0, 6'd0);
    run_traffic(50);
    drain_results();
    set_config(6'd63, 6'd63, 6'd63, 6'd63);
    run_traffic(50);
    drain_results();
    set_config(6'd63, 6'd0, 6'd63, 6'd0);
    run_traffic(50);
  endtask

  // long traffic under several random settings
  task automatic test_random_traffic();
    for (int p = 0; p < 5; p++) begin
      drain_results();
      set_config(6'($urandom), 6'($urandom), 6'($urandom_range(0, 8)), 6'($urandom));
      run_traffic(120);
    end
  endtask

  // each result word is taken at the edge that ends its strobe cycle
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_choices.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = expected_choices.pop_front();
        if (result.chosen_way !== want.chosen_way)
          report_mismatch($sformatf("chosen_way got %0d want %0d",
                                    result.chosen_way, want.chosen_way));
        if (result.line_number !== want.line_number)
          report_mismatch($sformatf("line_number got %0d want %0d",
                                    result.line_number, want.line_number));
        if (result.outcome !== want.outcome)
          report_mismatch($sformatf("outcome got %0d want %0d",
                                    result.outcome, want.outcome));
      end
    end
  end

  initial begin
    clear_predictor();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_config_corners();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("score_based_way_replacement test passed");
    end else begin
      $display("score_based_way_replacement test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("score_based_way_replacement test failed");
    $finish;
  end

endmodule
